// File: sv/timer_expiry_priority_queue_macros.svh
// Assertion macros used by the timer queue checker.
`ifndef TIMER_EXPIRY_PRIORITY_QUEUE_MACROS_SVH
`define TIMER_EXPIRY_PRIORITY_QUEUE_MACROS_SVH

// Same-cycle implication, sampled on aclk and idle during reset.
`define TMQ_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk and idle during reset.
`define TMQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/tmq_pkg.sv
// Types, codes and helpers shared by the timer queue modules.
`timescale 1ns / 1ps
package tmq_pkg;

    localparam int ID_W      = 6;
    localparam int TIMEOUT_W = 31;
    localparam int NOW_W     = 48;
    localparam int KIND_W    = 3;
    localparam int FIRE_W    = 7;
    localparam int MAX_FIRE  = 64;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_STOP  = 2'd1,
        OP_TICK  = 2'd2,
        OP_QUERY = 2'd3
    } op_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_STARTED    = 3'd0,
        KIND_FULL       = 3'd1,
        KIND_STOPPED    = 3'd2,
        KIND_NOT_ACTIVE = 3'd3,
        KIND_FIRED      = 3'd4,
        KIND_NONE       = 3'd5,
        KIND_EARLIEST   = 3'd6
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_POS,
        ST_CHK,
        ST_RM,
        ST_RM_LAST,
        ST_UP0,
        ST_UP,
        ST_DN0,
        ST_DN1,
        ST_DN2,
        ST_CONT,
        ST_TICK,
        ST_TICK_AFT,
        ST_QUERY,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]           opcode;
        logic [ID_W-1:0]      timer_id;
        logic [TIMEOUT_W-1:0] delay_ms;
        logic [NOW_W-1:0]     now_ms;
    } tmq_req_t;

    typedef struct packed {
        logic [KIND_W-1:0] result_kind;
        logic [ID_W-1:0]   result_id;
        logic [NOW_W-1:0]  expiry_ms;
        logic              last;
    } tmq_res_t;

    function automatic tmq_res_t mk_res(kind_t k, logic [ID_W-1:0] id,
                                        logic [NOW_W-1:0] e, logic l);
        tmq_res_t r;
        r.result_kind = k;
        r.result_id   = id;
        r.expiry_ms   = e;
        r.last        = l;
        return r;
    endfunction

endpackage

// File: sv/timer_expiry_priority_queue.sv
// Top level of the timer expiry priority queue.
`timescale 1ns / 1ps
// Keeps up to MAX_TIMERS one-shot timers in a binary min-heap held in a slot memory
// (id and expiry per slot) plus an id-to-slot memory, both with registered read data.
// Requests are handled one at a time. A query reads the root; a start of an idle timer
// inserts at the end and sifts up; a stop removes the entry, fills its slot with the
// last element and sifts it up or down; a restart pays for a removal and an insert.
// A tick removes each fired timer in turn. The heap memory port is read once per
// level moved up and up to twice per level moved down. After reset a clearing pass
// writes every entry of the id-to-slot memory, during which no request is accepted.
// Results leave through an output register, one per request except a tick that fires
// several timers, whose final result carries last.
module timer_expiry_priority_queue #(
    parameter int MAX_TIMERS = 64,
    parameter int TIME_BITS  = 48
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  tmq_pkg::tmq_req_t s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output tmq_pkg::tmq_res_t m_data
);
    import tmq_pkg::*;

    localparam int IDW = $clog2(MAX_TIMERS);
    localparam int EW  = IDW + TIME_BITS;

    logic           h_rd_en, h_wr_en, p_rd_en, p_wr_en;
    logic [IDW-1:0] h_rd_addr, h_wr_addr, p_rd_addr, p_wr_addr;
    logic [EW-1:0]  h_rd_data, h_wr_data;
    logic [IDW-1:0] p_rd_data, p_wr_data;
    logic           res_valid, res_ready;
    tmq_res_t       res;
    logic           m_valid_reg;
    tmq_res_t       m_data_reg;

    tmq_ctrl #(.MAX_TIMERS(MAX_TIMERS), .TIME_BITS(TIME_BITS)) u_ctrl (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data,
        .res_valid, .res_ready, .res,
        .h_rd_en, .h_rd_addr, .h_rd_data, .h_wr_en, .h_wr_addr, .h_wr_data,
        .p_rd_en, .p_rd_addr, .p_rd_data, .p_wr_en, .p_wr_addr, .p_wr_data
    );

    tmq_ram #(.DEPTH(MAX_TIMERS), .WIDTH(EW)) u_heap_ram (
        .aclk, .wr_en(h_wr_en), .wr_addr(h_wr_addr), .wr_data(h_wr_data),
        .rd_en(h_rd_en), .rd_addr(h_rd_addr), .rd_data(h_rd_data)
    );

    tmq_ram #(.DEPTH(MAX_TIMERS), .WIDTH(IDW)) u_pos_ram (
        .aclk, .wr_en(p_wr_en), .wr_addr(p_wr_addr), .wr_data(p_wr_data),
        .rd_en(p_rd_en), .rd_addr(p_rd_addr), .rd_data(p_rd_data)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res_ready) begin
            m_valid_reg <= res_valid;
        end
        if (res_valid && res_ready) begin
            m_data_reg <= res;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
endmodule

// File: sv/tmq_ram.sv
// Single-port-write, single-port-read synchronous memory with registered read data.
`timescale 1ns / 1ps
module tmq_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
endmodule

// File: sv/tmq_ctrl.sv
// Sequencer for heap insert, removal, sift and the command flows of the timer queue.
`timescale 1ns / 1ps
module tmq_ctrl #(
    parameter int MAX_TIMERS = 64,
    parameter int TIME_BITS  = 48
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  tmq_pkg::tmq_req_t                       s_data,
    output logic                                    res_valid,
    input  logic                                    res_ready,
    output tmq_pkg::tmq_res_t                       res,
    output logic                                    h_rd_en,
    output logic [$clog2(MAX_TIMERS)-1:0]           h_rd_addr,
    input  logic [$clog2(MAX_TIMERS)+TIME_BITS-1:0] h_rd_data,
    output logic                                    h_wr_en,
    output logic [$clog2(MAX_TIMERS)-1:0]           h_wr_addr,
    output logic [$clog2(MAX_TIMERS)+TIME_BITS-1:0] h_wr_data,
    output logic                                    p_rd_en,
    output logic [$clog2(MAX_TIMERS)-1:0]           p_rd_addr,
    input  logic [$clog2(MAX_TIMERS)-1:0]           p_rd_data,
    output logic                                    p_wr_en,
    output logic [$clog2(MAX_TIMERS)-1:0]           p_wr_addr,
    output logic [$clog2(MAX_TIMERS)-1:0]           p_wr_data
);
    import tmq_pkg::*;

    localparam int IDW = $clog2(MAX_TIMERS);
    localparam int CW  = $clog2(MAX_TIMERS + 1);
    localparam int SW  = ((TIME_BITS > TIMEOUT_W) ? TIME_BITS : TIMEOUT_W) + 1;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;
    localparam logic [CW-1:0]        CNT_MAX  = CW'(MAX_TIMERS);

    state_t                state_reg, state_next;
    tmq_req_t              req_reg, req_next;
    tmq_res_t              res_reg, res_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [IDW-1:0]        hole_reg, hole_next;
    logic [IDW-1:0]        ent_id_reg, ent_id_next;
    logic [TIME_BITS-1:0]  ent_key_reg, ent_key_next;
    logic [IDW-1:0]        rm_id_reg, rm_id_next;
    logic [TIME_BITS-1:0]  rm_key_reg, rm_key_next;
    logic [IDW-1:0]        lid_reg, lid_next;
    logic [TIME_BITS-1:0]  lkey_reg, lkey_next;
    logic                  up_moved_reg, up_moved_next;
    logic                  allow_dn_reg, allow_dn_next;
    logic                  ins_reg, ins_next;
    logic [FIRE_W-1:0]     fire_reg, fire_next;
    logic [IDW-1:0]        clr_reg, clr_next;

    logic [IDW-1:0]        rd_id;
    logic [TIME_BITS-1:0]  rd_key;
    logic [TIME_BITS-1:0]  now_t;
    logic [SW-1:0]         sum;
    logic [TIME_BITS-1:0]  exp_t;
    logic [IDW-1:0]        req_idx;
    logic [IDW-1:0]        parent;
    logic [IDW+1:0]        lft, rgt, cnt_x;
    logic [CW-1:0]         cnt_dec;
    logic                  id_ok;
    logic                  active;
    logic                  more;
    logic [FIRE_W-1:0]     fire_inc;
    logic                  wr_en;
    logic [IDW-1:0]        wr_slot;
    logic [IDW-1:0]        wr_id;
    logic [TIME_BITS-1:0]  wr_key;
    logic                  clr_en;

    assign rd_id    = h_rd_data[IDW+TIME_BITS-1:TIME_BITS];
    assign rd_key   = h_rd_data[TIME_BITS-1:0];
    assign now_t    = TIME_BITS'(req_reg.now_ms);
    // Expiry saturates at the top of the time range.
    assign sum      = SW'(now_t) + SW'(req_reg.delay_ms);
    assign exp_t    = (sum > SW'(TIME_MAX)) ? TIME_MAX : TIME_BITS'(sum);
    assign req_idx  = IDW'(req_reg.timer_id);
    assign parent   = IDW'((hole_reg - IDW'(1)) >> 1);
    assign lft      = {1'b0, hole_reg, 1'b1};
    assign rgt      = lft + (IDW+2)'(1);
    assign cnt_x    = (IDW+2)'(cnt_reg);
    assign cnt_dec  = cnt_reg - CW'(1);
    assign id_ok    = (32'(s_data.timer_id) < 32'(MAX_TIMERS));
    // An id is live only if its stored slot is occupied and points back at it.
    assign active   = ((IDW+2)'(hole_reg) < cnt_x) && (rd_id == req_idx);
    assign fire_inc = fire_reg + FIRE_W'(1);
    assign more     = (cnt_reg != '0) && (rd_key <= now_t) && (fire_inc < FIRE_W'(MAX_FIRE));

    assign h_wr_en   = wr_en;
    assign h_wr_addr = wr_slot;
    assign h_wr_data = {wr_id, wr_key};
    assign p_wr_en   = wr_en | clr_en;
    assign p_wr_addr = clr_en ? clr_reg : wr_id;
    assign p_wr_data = clr_en ? '0 : wr_slot;
    assign p_rd_addr = IDW'(s_data.timer_id);
    assign res       = res_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            cnt_reg   <= '0;
            clr_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            clr_reg   <= clr_next;
        end
        req_reg      <= req_next;
        res_reg      <= res_next;
        hole_reg     <= hole_next;
        ent_id_reg   <= ent_id_next;
        ent_key_reg  <= ent_key_next;
        rm_id_reg    <= rm_id_next;
        rm_key_reg   <= rm_key_next;
        lid_reg      <= lid_next;
        lkey_reg     <= lkey_next;
        up_moved_reg <= up_moved_next;
        allow_dn_reg <= allow_dn_next;
        ins_reg      <= ins_next;
        fire_reg     <= fire_next;
    end

    always_comb begin
        state_next    = state_reg;
        req_next      = req_reg;
        res_next      = res_reg;
        cnt_next      = cnt_reg;
        hole_next     = hole_reg;
        ent_id_next   = ent_id_reg;
        ent_key_next  = ent_key_reg;
        rm_id_next    = rm_id_reg;
        rm_key_next   = rm_key_reg;
        lid_next      = lid_reg;
        lkey_next     = lkey_reg;
        up_moved_next = up_moved_reg;
        allow_dn_next = allow_dn_reg;
        ins_next      = ins_reg;
        fire_next     = fire_reg;
        clr_next      = clr_reg;
        s_ready       = 1'b0;
        res_valid     = 1'b0;
        h_rd_en       = 1'b0;
        h_rd_addr     = '0;
        p_rd_en       = 1'b0;
        wr_en         = 1'b0;
        wr_slot       = hole_reg;
        wr_id         = ent_id_reg;
        wr_key        = ent_key_reg;
        clr_en        = 1'b0;

        unique case (state_reg)
            ST_CLEAR: begin
                clr_en   = 1'b1;
                clr_next = clr_reg + IDW'(1);
                if (clr_reg == IDW'(MAX_TIMERS - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    req_next  = s_data;
                    fire_next = '0;
                    ins_next  = 1'b0;
                    unique case (op_t'(s_data.opcode)) inside
                        OP_START, OP_STOP: begin
                            if (id_ok) begin
                                p_rd_en    = 1'b1;
                                state_next = ST_POS;
                            end else begin
                                res_next = mk_res((op_t'(s_data.opcode) == OP_START) ?
                                                  KIND_FULL : KIND_NOT_ACTIVE,
                                                  s_data.timer_id, '0, 1'b1);
                                state_next = ST_EMIT;
                            end
                        end
                        OP_TICK: begin
                            h_rd_en    = 1'b1;
                            state_next = ST_TICK;
                        end
                        OP_QUERY: begin
                            h_rd_en    = 1'b1;
                            state_next = ST_QUERY;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_POS: begin
                hole_next  = p_rd_data;
                h_rd_en    = 1'b1;
                h_rd_addr  = p_rd_data;
                state_next = ST_CHK;
            end
            ST_CHK: begin
                rm_id_next  = rd_id;
                rm_key_next = rd_key;
                if (active) begin
                    state_next = ST_RM;
                end else if (op_t'(req_reg.opcode) == OP_STOP) begin
                    res_next   = mk_res(KIND_NOT_ACTIVE, req_reg.timer_id, '0, 1'b1);
                    state_next = ST_EMIT;
                end else if (cnt_reg == CNT_MAX) begin
                    res_next   = mk_res(KIND_FULL, req_reg.timer_id, '0, 1'b1);
                    state_next = ST_EMIT;
                end else begin
                    ent_id_next   = req_idx;
                    ent_key_next  = exp_t;
                    hole_next     = IDW'(cnt_reg);
                    cnt_next      = cnt_reg + CW'(1);
                    up_moved_next = 1'b0;
                    allow_dn_next = 1'b0;
                    ins_next      = 1'b1;
                    state_next    = ST_UP0;
                end
            end
            ST_RM: begin
                // The last element fills the freed slot unless the freed slot was last.
                cnt_next      = cnt_dec;
                up_moved_next = 1'b0;
                allow_dn_next = 1'b1;
                if ((IDW+2)'(hole_reg) < (IDW+2)'(cnt_dec)) begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = IDW'(cnt_dec);
                    state_next = ST_RM_LAST;
                end else begin
                    state_next = ST_CONT;
                end
            end
            ST_RM_LAST: begin
                ent_id_next  = rd_id;
                ent_key_next = rd_key;
                state_next   = ST_UP0;
            end
            ST_UP0: begin
                if (hole_reg == '0) begin
                    if (!up_moved_reg && allow_dn_reg) begin
                        state_next = ST_DN0;
                    end else begin
                        wr_en      = 1'b1;
                        state_next = ST_CONT;
                    end
                end else begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = parent;
                    state_next = ST_UP;
                end
            end
            ST_UP: begin
                if (rd_key > ent_key_reg) begin
                    wr_en         = 1'b1;
                    wr_id         = rd_id;
                    wr_key        = rd_key;
                    hole_next     = parent;
                    up_moved_next = 1'b1;
                    state_next    = ST_UP0;
                end else if (!up_moved_reg && allow_dn_reg) begin
                    state_next = ST_DN0;
                end else begin
                    wr_en      = 1'b1;
                    state_next = ST_CONT;
                end
            end
            ST_DN0: begin
                if (lft >= cnt_x) begin
                    wr_en      = 1'b1;
                    state_next = ST_CONT;
                end else begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = IDW'(lft);
                    state_next = ST_DN1;
                end
            end
            ST_DN1: begin
                lid_next  = rd_id;
                lkey_next = rd_key;
                if (rgt < cnt_x) begin
                    h_rd_en    = 1'b1;
                    h_rd_addr  = IDW'(rgt);
                    state_next = ST_DN2;
                end else if (rd_key < ent_key_reg) begin
                    wr_en      = 1'b1;
                    wr_id      = rd_id;
                    wr_key     = rd_key;
                    hole_next  = IDW'(lft);
                    state_next = ST_DN0;
                end else begin
                    wr_en      = 1'b1;
                    state_next = ST_CONT;
                end
            end
            ST_DN2: begin
                // Only a strictly smaller child moves up; ties favor the left child.
                if (lkey_reg < ent_key_reg) begin
                    if (rd_key < lkey_reg) begin
                        wr_id     = rd_id;
                        wr_key    = rd_key;
                        hole_next = IDW'(rgt);
                    end else begin
                        wr_id     = lid_reg;
                        wr_key    = lkey_reg;
                        hole_next = IDW'(lft);
                    end
                    wr_en      = 1'b1;
                    state_next = ST_DN0;
                end else if (rd_key < ent_key_reg) begin
                    wr_en      = 1'b1;
                    wr_id      = rd_id;
                    wr_key     = rd_key;
                    hole_next  = IDW'(rgt);
                    state_next = ST_DN0;
                end else begin
                    wr_en      = 1'b1;
                    state_next = ST_CONT;
                end
            end
            ST_CONT: begin
                unique case (op_t'(req_reg.opcode))
                    OP_START: begin
                        if (!ins_reg) begin
                            ent_id_next   = req_idx;
                            ent_key_next  = exp_t;
                            hole_next     = IDW'(cnt_reg);
                            cnt_next      = cnt_reg + CW'(1);
                            up_moved_next = 1'b0;
                            allow_dn_next = 1'b0;
                            ins_next      = 1'b1;
                            state_next    = ST_UP0;
                        end else begin
                            res_next   = mk_res(KIND_STARTED, req_reg.timer_id,
                                                NOW_W'(ent_key_reg), 1'b1);
                            state_next = ST_EMIT;
                        end
                    end
                    OP_STOP: begin
                        res_next   = mk_res(KIND_STOPPED, req_reg.timer_id,
                                            NOW_W'(rm_key_reg), 1'b1);
                        state_next = ST_EMIT;
                    end
                    OP_TICK: begin
                        h_rd_en    = 1'b1;
                        state_next = ST_TICK_AFT;
                    end
                    default: state_next = ST_IDLE;
                endcase
            end
            ST_TICK: begin
                if ((cnt_reg != '0) && (rd_key <= now_t)) begin
                    rm_id_next  = rd_id;
                    rm_key_next = rd_key;
                    hole_next   = '0;
                    state_next  = ST_RM;
                end else begin
                    res_next   = mk_res(KIND_NONE, '0, '0, 1'b1);
                    state_next = ST_EMIT;
                end
            end
            ST_TICK_AFT: begin
                // The new root and the count of firings so far decide whether this firing closes the run.
                fire_next  = fire_inc;
                res_next   = mk_res(KIND_FIRED, ID_W'(rm_id_reg), NOW_W'(rm_key_reg), !more);
                state_next = ST_EMIT;
            end
            ST_QUERY: begin
                if (cnt_reg == '0) begin
                    res_next = mk_res(KIND_EARLIEST, '0, '1, 1'b1);
                end else begin
                    res_next = mk_res(KIND_EARLIEST, ID_W'(rd_id), NOW_W'(rd_key), 1'b1);
                end
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    if ((op_t'(req_reg.opcode) == OP_TICK) && !res_reg.last) begin
                        h_rd_en    = 1'b1;
                        state_next = ST_TICK;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule

// File: sv/tmq_checker.sv
// Port-level assertions for the timer queue and their bind to the top level.
`timescale 1ns / 1ps
`include "timer_expiry_priority_queue_macros.svh"
module tmq_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input tmq_pkg::tmq_req_t s_data,
    input logic              m_valid,
    input logic              m_ready,
    input tmq_pkg::tmq_res_t m_data
);
    import tmq_pkg::*;

    `TMQ_ASSERT_NEXT(a_res_hold, m_valid && !m_ready, m_valid && $stable(m_data), "stalled result changed")
    `TMQ_ASSERT_NEXT(a_busy_after_req, s_valid && s_ready, !s_ready, "request taken while busy")
    `TMQ_ASSERT_IMPL(a_single_last, m_valid && (m_data.result_kind != KIND_FIRED), m_data.last, "non-fire result without last")
    `TMQ_ASSERT_IMPL(a_reject_zero, m_valid && (m_data.result_kind == KIND_FULL || m_data.result_kind == KIND_NOT_ACTIVE), m_data.expiry_ms == '0, "rejected request reports expiry")
endmodule

bind timer_expiry_priority_queue tmq_checker u_tmq_checker (.*);
